@@ rtl/ssep_pkg.sv @@
// Shared types, codes and name tables for the event-stream parser.
`timescale 1ns / 1ps

package ssep_pkg;

  localparam int unsigned OutqDepthDefault = 8;

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_NAME  = 5'b00010,
    PH_COLON = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_SKIP  = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_COMMIT  = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [1:0] FIELD_DATA  = 2'd0;
  localparam logic [1:0] FIELD_EVENT = 2'd1;
  localparam logic [1:0] FIELD_ID    = 2'd2;
  localparam logic [1:0] FIELD_NONE  = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] tag;
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } result_t;

  // Results of one parsed byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [2:0] field_length(input logic [1:0] f);
    logic [2:0] len;
    case (f)
      FIELD_DATA:  len = 3'd4;
      FIELD_EVENT: len = 3'd5;
      FIELD_ID:    len = 3'd2;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] f, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (f)
      FIELD_DATA: begin
        case (pos)
          3'd0:    ch = 8'h64; // d
          3'd1:    ch = 8'h61; // a
          3'd2:    ch = 8'h74; // t
          3'd3:    ch = 8'h61; // a
          default: ch = 8'h00;
        endcase
      end
      FIELD_EVENT: begin
        case (pos)
          3'd0:    ch = 8'h65; // e
          3'd1:    ch = 8'h76; // v
          3'd2:    ch = 8'h65; // e
          3'd3:    ch = 8'h6E; // n
          3'd4:    ch = 8'h74; // t
          default: ch = 8'h00;
        endcase
      end
      FIELD_ID: begin
        case (pos)
          3'd0:    ch = 8'h69; // i
          3'd1:    ch = 8'h64; // d
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [1:0] tag,
                                          input logic [7:0] data, input logic has_data);
    result_t r;
    r.kind     = kind;
    r.tag      = tag;
    r.data     = data;
    r.has_data = has_data;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/ssep_core.sv @@
// Per-byte line parser: parse state and the results of one registered byte.
`timescale 1ns / 1ps

module ssep_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic [7:0]      byte_in,
  input  logic            eos_in,
  output ssep_pkg::push_t push
);
  import ssep_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] name_pos, name_pos_next;
  logic [2:0] cand, cand_next;
  logic [1:0] cur_field, cur_field_next;
  logic       id_nul, id_nul_next;
  logic       data_seen, data_seen_next;
  logic       after_cr, after_cr_next;

  always_comb begin
    logic [2:0] eff_pos;
    logic [2:0] eff_cand;
    logic [2:0] keep;
    logic [1:0] matched;
    logic [1:0] tag;
    logic [2:0] pos_inc;
    result_t    r0;
    result_t    r1;
    logic [1:0] n;

    phase_next     = phase;
    name_pos_next  = name_pos;
    cand_next      = cand;
    cur_field_next = cur_field;
    id_nul_next    = id_nul;
    data_seen_next = data_seen;
    after_cr_next  = after_cr;
    r0 = make_result(KIND_BYTE, FIELD_DATA, 8'h00, 1'b0);
    r1 = make_result(KIND_BYTE, FIELD_DATA, 8'h00, 1'b0);
    n  = 2'd0;

    // A name starting on this byte matches against a fresh candidate set.
    eff_pos  = (phase == PH_START) ? 3'd0 : name_pos;
    eff_cand = (phase == PH_START) ? 3'b111 : cand;
    for (int f = 0; f < 3; f++) begin
      keep[f] = eff_cand[f] && (eff_pos < field_length(2'(f)))
                && (name_char(2'(f), eff_pos) == byte_in);
    end
    pos_inc = (eff_pos == 3'd7) ? 3'd7 : eff_pos + 3'd1;

    matched = FIELD_NONE;
    for (int f = 2; f >= 0; f--) begin
      if (cand[f] && (name_pos == field_length(2'(f)))) begin
        matched = 2'(f);
      end
    end

    tag = (phase == PH_NAME) ? matched : cur_field;

    if (byte_valid) begin
      if (eos_in) begin
        if (phase == PH_COLON || phase == PH_VALUE) begin
          r0 = make_result(KIND_DISCARD, cur_field, 8'h00, 1'b0);
          n  = 2'd1;
        end
        if (data_seen) begin
          if (n == 2'd0) begin
            r0 = make_result(KIND_END, FIELD_DATA, 8'h00, 1'b1);
          end else begin
            r1 = make_result(KIND_END, FIELD_DATA, 8'h00, 1'b1);
          end
          n = n + 2'd1;
        end
        phase_next     = PH_START;
        name_pos_next  = 3'd0;
        cand_next      = 3'b111;
        cur_field_next = FIELD_DATA;
        id_nul_next    = 1'b0;
        data_seen_next = 1'b0;
        after_cr_next  = 1'b0;
      end else if (after_cr && byte_in == CHAR_LF) begin
        after_cr_next = 1'b0;
      end else if (byte_in == CHAR_CR || byte_in == CHAR_LF) begin
        after_cr_next = (byte_in == CHAR_CR);
        unique case (phase)
          PH_START: begin
            r0 = make_result(KIND_END, FIELD_DATA, 8'h00, data_seen);
            n  = 2'd1;
            data_seen_next = 1'b0;
          end
          PH_NAME, PH_COLON, PH_VALUE: begin
            // A bare name line never carries an id NUL.
            if (tag != FIELD_NONE) begin
              if (tag == FIELD_ID && id_nul && phase != PH_NAME) begin
                r0 = make_result(KIND_DISCARD, tag, 8'h00, 1'b0);
              end else begin
                r0 = make_result(KIND_COMMIT, tag, 8'h00, 1'b0);
                if (tag == FIELD_DATA) begin
                  data_seen_next = 1'b1;
                end
              end
              n = 2'd1;
            end
          end
          default: begin
          end
        endcase
        phase_next  = PH_START;
        id_nul_next = 1'b0;
      end else begin
        after_cr_next = 1'b0;
        unique case (phase)
          PH_START, PH_NAME: begin
            if (byte_in == CHAR_COLON) begin
              if (phase == PH_NAME && matched != FIELD_NONE) begin
                cur_field_next = matched;
                id_nul_next    = 1'b0;
                phase_next     = PH_COLON;
              end else begin
                phase_next = PH_SKIP;
              end
            end else begin
              cand_next     = keep;
              name_pos_next = pos_inc;
              phase_next    = (keep == 3'b000) ? PH_SKIP : PH_NAME;
            end
          end
          PH_COLON, PH_VALUE: begin
            phase_next = PH_VALUE;
            if (!(phase == PH_COLON && byte_in == CHAR_SPACE)) begin
              if (cur_field == FIELD_ID && byte_in == CHAR_NUL) begin
                id_nul_next = 1'b1;
              end
              r0 = make_result(KIND_BYTE, cur_field, byte_in, 1'b0);
              n  = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
    push.count  = n;
    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      name_pos  <= 3'd0;
      cand      <= 3'b111;
      cur_field <= FIELD_DATA;
      id_nul    <= 1'b0;
      data_seen <= 1'b0;
      after_cr  <= 1'b0;
    end else begin
      phase     <= phase_next;
      name_pos  <= name_pos_next;
      cand      <= cand_next;
      cur_field <= cur_field_next;
      id_nul    <= id_nul_next;
      data_seen <= data_seen_next;
      after_cr  <= after_cr_next;
    end
  end

  a_two_only_on_eos: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (byte_valid && eos_in))
    else $error("two results from a byte that is not end of stream");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && eos_in) |=> (phase == PH_START && !data_seen && !after_cr))
    else $error("state not cleared after end of stream");

  a_lf_after_cr_silent: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !eos_in && after_cr && byte_in == CHAR_LF) |->
      (push.count == 2'd0 && phase_next == phase))
    else $error("LF after CR produced results or moved the phase");

endmodule

@@ rtl/ssep_outq.sv @@
// Result queue between the parser and the output channel.
`timescale 1ns / 1ps

module ssep_outq #(
  parameter int unsigned Depth = ssep_pkg::OutqDepthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssep_pkg::push_t            push,
  output ssep_pkg::result_t          head,
  output logic                       head_valid,
  input  logic                       head_stall,
  output logic [$clog2(Depth+1)-1:0] count
);
  import ssep_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW-1:0] wr_ptr_inc;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_inc = ptr_inc(wr_ptr);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && !head_stall;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_inc;
      end else if (push.count == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_inc);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (CntW'(push.count) <= CntW'(Depth) - count))
    else $error("result queue overflow");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd0 && !pop) |=> $stable(count))
    else $error("queue count moved without push or pop");

  a_push_code: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd3))
    else $error("illegal push count");

endmodule

@@ rtl/sse_event_stream_parser_unit.sv @@
// Top level of the server-sent event stream parser.
`timescale 1ns / 1ps

//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+----------------------------------------
//  input     | in        | in_valid / in_stall | stream_byte, end_of_stream
//  result    | out       | out_valid/out_stall | item_kind, field_tag, value_byte,
//            |           |                     | event_has_data, last_of_run
//
//  One byte request is taken per cycle while in_stall is low. It is held in the input
//  register, then the parser updates its line state and writes its zero to two results
//  into the result queue, whose head drives the result channel.
//  Reset (rst, synchronous) returns the parser to line start and empties the queue.
//  in_stall rises only when the result queue could not absorb the worst case of two
//  results for the byte in flight plus the next one; out_stall just holds the queue.

module sse_event_stream_parser_unit #(
  parameter int unsigned OutqDepth = ssep_pkg::OutqDepthDefault  // at least 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] stream_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] item_kind,
  output logic [1:0] field_tag,
  output logic [7:0] value_byte,
  output logic       event_has_data,
  output logic       last_of_run
);
  import ssep_pkg::*;

  localparam int unsigned CntW = $clog2(OutqDepth + 1);

  // Input register: one byte request waiting for the parser.
  logic            byte_valid;
  logic [7:0]      byte_reg;
  logic            eos_reg;
  logic            in_take;

  push_t           push;
  result_t         head;
  logic [CntW-1:0] q_count;

  // Reserve room for two results of the byte in flight and two of the next.
  assign in_stall = byte_valid ? (q_count > CntW'(OutqDepth - 4))
                               : (q_count > CntW'(OutqDepth - 2));
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= in_take;
    end
  end

  // Payload: load on accept only, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_reg <= stream_byte;
      eos_reg  <= end_of_stream;
    end
  end

  ssep_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_in    (byte_reg),
    .eos_in     (eos_reg),
    .push       (push)
  );

  ssep_outq #(
    .Depth (OutqDepth)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .head       (head),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .count      (q_count)
  );

  // Drive the result fields straight from the queue head.
  assign item_kind      = head.kind;
  assign field_tag      = head.tag;
  assign value_byte     = head.data;
  assign event_has_data = head.has_data;
  assign last_of_run    = head.last;

endmodule
